FILE: rtl/core/pip_pkg.sv
package pip_pkg;

   localparam int MAX_VERTICES_DEF = 64;
   localparam int COORD_WIDTH_DEF = 16;
   localparam int QUEUE_DEPTH = 2;

   // Operation codes on the request channel
   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_TEST   = 2'd2;

   // Decoded command kinds handed from the front end to the back end
   typedef logic [1:0] cmd_kind_type;
   localparam cmd_kind_type CMD_NOP    = 2'd0;
   localparam cmd_kind_type CMD_CLEAR  = 2'd1;
   localparam cmd_kind_type CMD_APPEND = 2'd2;
   localparam cmd_kind_type CMD_TEST   = 2'd3;

   localparam int CMD_KIND_WIDTH = 2;

endpackage

FILE: rtl/core/pip_front.sv
module pip_front #(
   parameter int COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_operation,
   input  logic signed [COORD_WIDTH-1:0] req_coord_x,
   input  logic signed [COORD_WIDTH-1:0] req_coord_y,
   output logic                          cmd_valid,
   input  logic                          cmd_full,
   output pip_pkg::cmd_kind_type         cmd_kind,
   output logic signed [COORD_WIDTH-1:0] cmd_x,
   output logic signed [COORD_WIDTH-1:0] cmd_y
);
   import pip_pkg::*;

   logic                          hold_v_ff;
   logic                          hold_v_in;
   cmd_kind_type                  kind_ff;
   cmd_kind_type                  kind_in;
   logic signed [COORD_WIDTH-1:0] x_ff;
   logic signed [COORD_WIDTH-1:0] y_ff;
   logic                          take;
   logic                          push;

   assign push      = hold_v_ff && !cmd_full;
   assign req_stall = hold_v_ff && cmd_full;
   assign take      = req_valid && !req_stall;

   always_comb begin
      case (req_operation)
         OP_CLEAR:  kind_in = CMD_CLEAR;
         OP_APPEND: kind_in = CMD_APPEND;
         OP_TEST:   kind_in = CMD_TEST;
         default:   kind_in = CMD_NOP;
      endcase
   end

   always_comb begin
      hold_v_in = hold_v_ff;
      if (push) begin
         hold_v_in = 1'b0;
      end
      if (take) begin
         hold_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
      end else begin
         hold_v_ff <= hold_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff <= kind_in;
         x_ff    <= req_coord_x;
         y_ff    <= req_coord_y;
      end
   end

   assign cmd_valid = hold_v_ff;
   assign cmd_kind  = kind_ff;
   assign cmd_x     = x_ff;
   assign cmd_y     = y_ff;

endmodule

FILE: rtl/core/pip_queue.sv
module pip_queue #(
   parameter int DATA_W = 2 * pip_pkg::COORD_WIDTH_DEF + pip_pkg::CMD_KIND_WIDTH,
   parameter int DEPTH  = pip_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output logic [DATA_W-1:0] pop_data
);
   localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PTRW-1:0]   wr_ptr_ff;
   logic [PTRW-1:0]   wr_ptr_in;
   logic [PTRW-1:0]   rd_ptr_ff;
   logic [PTRW-1:0]   rd_ptr_in;
   logic [CNTW-1:0]   cnt_ff;
   logic [CNTW-1:0]   cnt_in;
   logic              do_push;
   logic              do_pop;

   assign full      = (cnt_ff == CNTW'(DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTRW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTRW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNTW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/core/pip_back.sv
module pip_back #(
   parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
   parameter int COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 cmd_valid,
   input  pip_pkg::cmd_kind_type                cmd_kind,
   input  logic signed [COORD_WIDTH-1:0]        cmd_x,
   input  logic signed [COORD_WIDTH-1:0]        cmd_y,
   output logic                                 cmd_pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_status,
   output logic                                 rsp_inside_res,
   output logic [$clog2(MAX_VERTICES+1)-1:0]    rsp_vertices_held
);
   import pip_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int DW = W + 1;
   localparam int PW = 2 * DW;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        iss_ff, iss_in;
   logic signed [W-1:0]  px_ff, px_in;
   logic signed [W-1:0]  py_ff, py_in;

   logic [2*W-1:0]       vmem [MAX_VERTICES];
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [2*W-1:0]       rd_data_ff;

   logic                 a_v_ff, a_v_in;
   logic                 a_first_ff, a_first_in;
   logic                 a_last_ff, a_last_in;
   logic signed [W-1:0]  prev_x_ff, prev_y_ff;
   logic signed [W-1:0]  qx, qy;

   logic                 b_v_ff, b_v_in;
   logic                 b_last_ff, b_last_in;
   logic                 b_cond_ff, b_cond_in;
   logic signed [DW-1:0] b_dx_ff, b_dx_in;
   logic signed [DW-1:0] b_d_ff, b_d_in;
   logic signed [DW-1:0] b_dxe_ff, b_dxe_in;
   logic signed [DW-1:0] b_e_ff, b_e_in;
   logic signed [DW-1:0] d_raw, e_raw;

   logic                 c_v_ff, c_v_in;
   logic                 c_last_ff, c_last_in;
   logic                 c_cond_ff, c_cond_in;
   logic signed [PW-1:0] c_p_ff, c_p_in;
   logic signed [PW-1:0] c_q_ff, c_q_in;

   logic                 inside_ff, inside_in;
   logic                 flip;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_load;
   logic                 rsp_status_in, rsp_inside_in;
   logic [CW-1:0]        rsp_held_in;
   logic                 rsp_status_ff, rsp_inside_ff;
   logic [CW-1:0]        rsp_held_ff;
   logic                 out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign cmd_pop  = (state_ff == ST_IDLE) && cmd_valid && out_free;

   assign qx = rd_data_ff[2*W-1:W];
   assign qy = rd_data_ff[W-1:0];

   // Edge geometry: i is the vertex just read, j the one before it
   always_comb begin
      d_raw     = DW'(prev_y_ff) - DW'(qy);
      e_raw     = DW'(py_ff) - DW'(qy);
      b_cond_in = ((qy <= py_ff) && (py_ff < prev_y_ff)) ||
                  ((prev_y_ff <= py_ff) && (py_ff < qy));
      b_dx_in   = DW'(px_ff) - DW'(qx);
      b_dxe_in  = DW'(prev_x_ff) - DW'(qx);
      if (d_raw < 0) begin
         b_d_in = -d_raw;
         b_e_in = -e_raw;
      end else begin
         b_d_in = d_raw;
         b_e_in = e_raw;
      end
      b_v_in    = a_v_ff && !a_first_ff;
      b_last_in = a_last_ff;
   end

   always_comb begin
      c_p_in    = b_dx_ff * b_d_ff;
      c_q_in    = b_dxe_ff * b_e_ff;
      c_v_in    = b_v_ff;
      c_last_in = b_last_ff;
      c_cond_in = b_cond_ff;
   end

   assign flip = c_cond_ff && (c_p_ff < c_q_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      iss_in        = iss_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[AW-1:0];
      rd_en         = 1'b0;
      rd_addr       = iss_ff[AW-1:0];
      a_v_in        = 1'b0;
      a_first_in    = 1'b0;
      a_last_in     = 1'b0;
      inside_in     = inside_ff;
      rsp_load      = 1'b0;
      rsp_status_in = 1'b0;
      rsp_inside_in = 1'b0;
      rsp_held_in   = count_ff;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_pop) begin
               case (cmd_kind)
                  CMD_CLEAR: begin
                     count_in    = '0;
                     rsp_load    = 1'b1;
                     rsp_held_in = '0;
                  end
                  CMD_APPEND: begin
                     rsp_load = 1'b1;
                     if (count_ff == CW'(MAX_VERTICES)) begin
                        rsp_status_in = 1'b1;
                     end else begin
                        wr_en       = 1'b1;
                        count_in    = count_ff + CW'(1);
                        rsp_held_in = count_ff + CW'(1);
                     end
                  end
                  CMD_TEST: begin
                     if (count_ff == '0) begin
                        rsp_load = 1'b1;
                     end else begin
                        // Prime the walk with the last vertex as the first edge's start
                        rd_en      = 1'b1;
                        rd_addr    = AW'(count_ff - CW'(1));
                        a_v_in     = 1'b1;
                        a_first_in = 1'b1;
                        iss_in     = '0;
                        px_in      = cmd_x;
                        py_in      = cmd_y;
                        inside_in  = 1'b0;
                        state_in   = ST_WALK;
                     end
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_WALK: begin
            rd_en     = 1'b1;
            a_v_in    = 1'b1;
            a_last_in = (iss_ff == count_ff - CW'(1));
            iss_in    = iss_ff + CW'(1);
            if (a_last_in) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (c_v_ff && c_last_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (c_v_ff) begin
         inside_in = inside_ff ^ flip;
         if (c_last_ff) begin
            rsp_load      = 1'b1;
            rsp_inside_in = inside_ff ^ flip;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         a_v_ff       <= 1'b0;
         b_v_ff       <= 1'b0;
         c_v_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         a_v_ff       <= a_v_in;
         b_v_ff       <= b_v_in;
         c_v_ff       <= c_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_ff     <= iss_in;
      px_ff      <= px_in;
      py_ff      <= py_in;
      inside_ff  <= inside_in;
      a_first_ff <= a_first_in;
      a_last_ff  <= a_last_in;
      if (a_v_ff) begin
         prev_x_ff <= qx;
         prev_y_ff <= qy;
      end
      b_last_ff  <= b_last_in;
      b_cond_ff  <= b_cond_in;
      b_dx_ff    <= b_dx_in;
      b_d_ff     <= b_d_in;
      b_dxe_ff   <= b_dxe_in;
      b_e_ff     <= b_e_in;
      c_last_ff  <= c_last_in;
      c_cond_ff  <= c_cond_in;
      c_p_ff     <= c_p_in;
      c_q_ff     <= c_q_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_inside_ff <= rsp_inside_in;
         rsp_held_ff   <= rsp_held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         vmem[wr_addr] <= {cmd_x, cmd_y};
      end
      if (rd_en) begin
         rd_data_ff <= vmem[rd_addr];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_inside_res    = rsp_inside_ff;
   assign rsp_vertices_held = rsp_held_ff;

endmodule

FILE: rtl/core/point_in_polygon_test_unit.sv
// Even-odd crossing point-in-polygon test over a stored polygon of up to
// MAX_VERTICES signed vertices. Each request item clears the polygon,
// appends a vertex (dropped with rsp_status = 1 when the store is full) or
// tests a point; every item returns exactly one response item carrying the
// vertex count after it. A front end registers and decodes items into a
// short queue, so requests keep flowing while the back end works. In the
// back end a clear, an append or an unused code is done in the idle state;
// a test of a non-empty polygon reads its vertices through the single
// read port of the vertex memory, one vertex per cycle, into a three-stage
// edge pipeline (geometry, cross-multiply, compare and flip). Edge
// comparisons are exact: the division of the textbook form is replaced by
// a sign-corrected cross-multiplication at full width.
module point_in_polygon_test_unit #(
   parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
   parameter int COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_operation,
   input  logic signed [COORD_WIDTH-1:0]     req_coord_x,
   input  logic signed [COORD_WIDTH-1:0]     req_coord_y,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_status,
   output logic                              rsp_inside_res,
   output logic [$clog2(MAX_VERTICES+1)-1:0] rsp_vertices_held
);
   import pip_pkg::*;

   localparam int QW = CMD_KIND_WIDTH + 2 * COORD_WIDTH;

   logic                          f_valid;
   logic                          q_full;
   cmd_kind_type                  f_kind;
   logic signed [COORD_WIDTH-1:0] f_x;
   logic signed [COORD_WIDTH-1:0] f_y;
   logic                          q_valid;
   logic [QW-1:0]                 q_data;
   logic                          q_pop;
   cmd_kind_type                  q_kind;
   logic signed [COORD_WIDTH-1:0] q_x;
   logic signed [COORD_WIDTH-1:0] q_y;

   pip_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_coord_x   (req_coord_x),
      .req_coord_y   (req_coord_y),
      .cmd_valid     (f_valid),
      .cmd_full      (q_full),
      .cmd_kind      (f_kind),
      .cmd_x         (f_x),
      .cmd_y         (f_y)
   );

   pip_queue #(
      .DATA_W (QW),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_data  ({f_kind, f_x, f_y}),
      .full       (q_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_data   (q_data)
   );

   assign q_kind = q_data[QW-1:2*COORD_WIDTH];
   assign q_x    = q_data[2*COORD_WIDTH-1:COORD_WIDTH];
   assign q_y    = q_data[COORD_WIDTH-1:0];

   pip_back #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_WIDTH  (COORD_WIDTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (q_valid),
      .cmd_kind          (q_kind),
      .cmd_x             (q_x),
      .cmd_y             (q_y),
      .cmd_pop           (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_inside_res    (rsp_inside_res),
      .rsp_vertices_held (rsp_vertices_held)
   );

`ifndef SYNTHESIS
   // A full-store report and an inside answer come from different operations
   a_status_xor_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_status && rsp_inside_res))
      else $error("status and inside both set");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |->
         (rsp_vertices_held == ($clog2(MAX_VERTICES+1))'(MAX_VERTICES)))
      else $error("full report with store not full");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_vertices_held <= ($clog2(MAX_VERTICES+1))'(MAX_VERTICES)))
      else $error("vertex count beyond capacity");

   // Fewer than three vertices always cross an even number of edges
   a_inside_needs_area: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_inside_res) |->
         (rsp_vertices_held >= ($clog2(MAX_VERTICES+1))'(3)))
      else $error("inside reported for degenerate polygon");
`endif

endmodule

FILE: tb/sv/pip_checker.sv
`timescale 1ns / 1ps

module pip_checker
   import pip_pkg::*;
#(
   parameter int HELD_W = $clog2(MAX_VERTICES_DEF + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [1:0]                        req_operation,
   input  logic signed [COORD_WIDTH_DEF-1:0] req_coord_x,
   input  logic signed [COORD_WIDTH_DEF-1:0] req_coord_y,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic                              rsp_status,
   input  logic                              rsp_inside_res,
   input  logic [HELD_W-1:0]                 rsp_vertices_held,
   output int                                fail_count,
   output int                                pending,
   output int                                checked,
   output int                                dropped
);

   typedef struct packed {
      logic              status;
      logic              in_poly;
      logic [HELD_W-1:0] held;
   } answer_type;

   answer_type answers_due[$];
   logic signed [COORD_WIDTH_DEF-1:0] poly_x [MAX_VERTICES_DEF];
   logic signed [COORD_WIDTH_DEF-1:0] poly_y [MAX_VERTICES_DEF];
   int vertex_total;
   int errors;
   int checked_n;
   int dropped_n;

   // Even-odd crossing count; the left-of-edge test is cross-multiplied so no
   // division and no rounding are involved.
   function automatic logic point_inside(input longint px, input longint py);
      longint xi, yi, xj, yj, d, e;
      logic flip;
      int j;
      flip = 1'b0;
      j = vertex_total - 1;
      for (int i = 0; i < vertex_total; i++) begin
         xi = poly_x[i];
         yi = poly_y[i];
         xj = poly_x[j];
         yj = poly_y[j];
         if ((yi <= py && py < yj) || (yj <= py && py < yi)) begin
            d = yj - yi;
            e = py - yi;
            // keep the divisor positive so the inequality keeps its direction
            if (d < 0) begin
               d = -d;
               e = -e;
            end
            if ((px - xi) * d < (xj - xi) * e) flip = ~flip;
         end
         j = i;
      end
      return flip;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      answer_type got;
      answer_type want;
      if (reset) begin
         vertex_total = 0;
         errors = 0;
         checked_n = 0;
         dropped_n = 0;
         answers_due.delete();
      end else begin
         // compare first so an item accepted at this edge cannot cover a stray result
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_status, rsp_inside_res, rsp_vertices_held};
            if (answers_due.size() == 0) begin
               $display("%0t: result item with none expected, expected nothing, actual %0d/%0d/%0d",
                        $time, got.status, got.in_poly, got.held);
               errors++;
            end else begin
               want = answers_due.pop_front();
               check_field("status", want.status, got.status);
               check_field("inside_res", want.in_poly, got.in_poly);
               check_field("vertices_held", want.held, got.held);
               checked_n++;
            end
         end
         if (req_valid && !req_stall) begin
            want = '0;
            case (req_operation)
               OP_CLEAR: vertex_total = 0;
               OP_APPEND: begin
                  if (vertex_total >= MAX_VERTICES_DEF) begin
                     want.status = 1'b1;
                     dropped_n++;
                  end else begin
                     poly_x[vertex_total] = req_coord_x;
                     poly_y[vertex_total] = req_coord_y;
                     vertex_total++;
                  end
               end
               OP_TEST: want.in_poly = point_inside(req_coord_x, req_coord_y);
               default: ;
            endcase
            want.held = vertex_total[HELD_W-1:0];
            answers_due.push_back(want);
         end
      end
      fail_count <= errors;
      pending <= answers_due.size();
      checked <= checked_n;
      dropped <= dropped_n;
   end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import pip_pkg::*;

   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam int HELD_W = $clog2(MAX_VERTICES_DEF + 1);
   localparam int QUIET_LIMIT = 3000;
   localparam int ITEMS_PER_PHASE = 225;

   typedef logic signed [COORD_WIDTH_DEF-1:0] coord_type;

   localparam coord_type C_MIN = 16'sh8000;
   localparam coord_type C_MAX = 16'sh7fff;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [1:0] req_operation;
   coord_type req_coord_x;
   coord_type req_coord_y;
   logic rsp_valid;
   logic rsp_stall;
   logic rsp_status;
   logic rsp_inside_res;
   logic [HELD_W-1:0] rsp_vertices_held;

   int fail_count;
   int pending;
   int checked;
   int dropped;

   int idle_pct;
   int stall_pct;
   int quiet;
   int counted;
   int n_clear;
   int n_append;
   int n_test;
   int n_spare;

   point_in_polygon_test_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_inside_res   (rsp_inside_res),
      .rsp_vertices_held(rsp_vertices_held)
   );

   pip_checker #(.HELD_W(HELD_W)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_inside_res   (rsp_inside_res),
      .rsp_vertices_held(rsp_vertices_held),
      .fail_count       (fail_count),
      .pending          (pending),
      .checked          (checked),
      .dropped          (dropped)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   function automatic coord_type pick_coord(input int mid, input int span);
      int v;
      v = mid - span + int'($urandom_range(2 * span));
      if (v < -32768) v = -32768;
      if (v > 32767) v = 32767;
      return v[COORD_WIDTH_DEF-1:0];
   endfunction

   task automatic send_item(input logic [1:0] op, input coord_type x, input coord_type y);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_coord_x <= x;
      req_coord_y <= y;
      // hold the item until it is taken
      do @(posedge clock); while (req_stall);
      case (op)
         OP_CLEAR:  n_clear++;
         OP_APPEND: n_append++;
         OP_TEST:   n_test++;
         default:   n_spare++;
      endcase
      if (op != OP_SPARE) counted++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic polygon_round(input bit big);
      coord_type vx [67];
      coord_type vy [67];
      int n, span, mx, my, tests, r, v;
      send_item(OP_CLEAR, pick_coord(0, 32768), pick_coord(0, 32768));
      r = $urandom_range(9);
      if (big) n = $urandom_range(67, 65);
      else if (r < 7) n = $urandom_range(8, 1);
      else if (r < 9) n = $urandom_range(24, 9);
      else n = $urandom_range(66, 40);
      // tight boxes make shared y values and vertex hits common
      r = $urandom_range(9);
      if (r < 5) span = 8;
      else if (r < 8) span = 1000;
      else span = 32768;
      mx = (span == 32768) ? 0 : int'($urandom_range(65535)) - 32768;
      my = (span == 32768) ? 0 : int'($urandom_range(65535)) - 32768;
      for (int k = 0; k < n; k++) begin
         vx[k] = pick_coord(mx, span);
         vy[k] = pick_coord(my, span);
         send_item(OP_APPEND, vx[k], vy[k]);
      end
      tests = $urandom_range(6, 2);
      for (int k = 0; k < tests; k++) begin
         r = $urandom_range(9);
         v = $urandom_range(n - 1);
         if (r < 2) send_item(OP_TEST, vx[v], vy[v]);
         else if (r < 5) send_item(OP_TEST, pick_coord(mx, span), vy[v]);
         else send_item(OP_TEST, pick_coord(mx, span + span / 2),
                        pick_coord(my, span + span / 2));
      end
   endtask

   task automatic noise_burst();
      int k;
      k = $urandom_range(4, 1);
      repeat (k) begin
         send_item(2'($urandom_range(3)), pick_coord(0, 32768), pick_coord(0, 32768));
      end
   endtask

   task automatic directed_items();
      send_item(OP_TEST, 0, 0);
      send_item(OP_SPARE, C_MIN, C_MAX);
      send_item(OP_APPEND, C_MAX, C_MIN);
      send_item(OP_TEST, C_MAX, C_MIN);
      send_item(OP_CLEAR, C_MAX, C_MAX);
      send_item(OP_APPEND, C_MIN, C_MIN);
      send_item(OP_APPEND, C_MAX, C_MIN);
      send_item(OP_APPEND, C_MAX, C_MAX);
      send_item(OP_APPEND, C_MIN, C_MAX);
      send_item(OP_TEST, 0, 0);
      send_item(OP_TEST, C_MIN, C_MIN);
      send_item(OP_TEST, C_MAX, 0);
      send_item(OP_TEST, C_MIN, 0);
      send_item(OP_TEST, 0, C_MAX);
      send_item(OP_TEST, 0, C_MIN);
      send_item(OP_TEST, -32767, 32766);
      send_item(OP_CLEAR, 0, 0);
      send_item(OP_APPEND, 0, 0);
      send_item(OP_APPEND, 10, 0);
      send_item(OP_APPEND, 0, 10);
      send_item(OP_TEST, 5, 5);
      send_item(OP_TEST, 1, 1);
      send_item(OP_TEST, 0, 0);
      send_item(OP_TEST, -1, 0);
      send_item(OP_SPARE, 0, 0);
   endtask

   initial begin
      int budget;
      bit first;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_operation <= OP_CLEAR;
      req_coord_x <= '0;
      req_coord_y <= '0;
      rsp_stall <= 1'b0;
      stall_pct <= 0;
      idle_pct = 0;
      counted = 0;
      n_clear = 0;
      n_append = 0;
      n_test = 0;
      n_spare = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               idle_pct = 20;
               stall_pct <= 73;
            end
            1: begin
               idle_pct = 73;
               stall_pct <= 20;
            end
            default: begin
               idle_pct = 0;
               stall_pct <= 0;
            end
         endcase
         if (ph == 0) directed_items();
         budget = counted + ITEMS_PER_PHASE;
         first = 1'b1;
         while (counted < budget) begin
            // each phase opens by overfilling the store
            if (first || $urandom_range(9) < 8) polygon_round(first);
            else noise_burst();
            first = 1'b0;
            if ($urandom_range(19) == 0) drain();
         end
         drain();
      end

      repeat (100) @(posedge clock);
      $display("run covered %0d clears, %0d appends (%0d dropped on a full store), %0d tests",
               n_clear, n_append, dropped, n_test);
      $display("plus %0d unused-code items; %0d result items checked", n_spare, checked);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
